@@ rtl/ipv4_address_text_parser_core_macros.svh @@
// Assertion macros for the address parser top level.
`ifndef IPV4_ADDRESS_TEXT_PARSER_CORE_MACROS_SVH
`define IPV4_ADDRESS_TEXT_PARSER_CORE_MACROS_SVH

// Check on every rising clock edge outside reset.
`define IPV4ATP_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that also holds across reset.
`define IPV4ATP_ASSERT_RST(name, expr, msg) \
  name: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

@@ rtl/ipv4atp_pkg.sv @@
// Types, codes and constants of the IPv4 address text parser.
package ipv4atp_pkg;

  localparam logic [15:0] DEFAULT_PORT_RESET = 16'd27500;
  localparam int unsigned OCTET_MAX          = 255;
  localparam int unsigned PORT_MAX           = 65535;
  localparam int          ACC_W              = 20;
  localparam int          ACC_PROD_W         = ACC_W + 4;

  localparam logic [2:0] WORD_LEN  = 3'd5;
  localparam logic [2:0] WORD_FAIL = 3'd7;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;

  typedef enum logic [1:0] {
    ST_IPV4        = 2'd0,
    ST_LOOPBACK    = 2'd1,
    ST_NOT_NUMERIC = 2'd2,
    ST_REJECTED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_NOT_NUMERIC = 2'd2,
    ERR_REJECTED    = 2'd3
  } err_t;

  typedef enum logic [4:0] {
    PH_OCT0 = 5'b00001,
    PH_OCT1 = 5'b00010,
    PH_OCT2 = 5'b00100,
    PH_OCT3 = 5'b01000,
    PH_PORT = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  octet_a;
    logic [7:0]  octet_b;
    logic [7:0]  octet_c;
    logic [7:0]  octet_d;
    logic [15:0] port_number;
  } out_item_t;

  // Characters of the loopback word, by match position.
  function automatic logic [7:0] loop_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h6c; // l
      3'd1:    c = 8'h6f; // o
      3'd2:    c = 8'h63; // c
      3'd3:    c = 8'h61; // a
      3'd4:    c = 8'h6c; // l
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/ipv4atp_parser.sv @@
// Parser state and one-character step logic with result formation.
module ipv4atp_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  ipv4atp_pkg::in_item_t  item,
  input  logic [15:0]            default_port,
  output ipv4atp_pkg::out_item_t result
);

  ipv4atp_pkg::phase_t            phase, phase_next;
  logic [ipv4atp_pkg::ACC_W-1:0]  acc, acc_next;
  logic                           digit_seen, digit_seen_next;
  logic [7:0]                     octets [4];
  logic [7:0]                     octets_next [4];
  logic [2:0]                     match_pos, match_pos_next;
  ipv4atp_pkg::err_t              err, err_next;
  logic                           ended, ended_next;

  logic                                is_digit;
  logic [ipv4atp_pkg::ACC_PROD_W-1:0]  acc_sum;
  logic                                sep_ok;
  logic [1:0]                          oct_idx;
  ipv4atp_pkg::phase_t                 phase_adv;

  always_comb begin
    is_digit = (item.ch >= ipv4atp_pkg::CH_DIG0) && (item.ch <= ipv4atp_pkg::CH_DIG9);
    // acc * 10 + digit as two shifts and two adds
    acc_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
              + {{(ipv4atp_pkg::ACC_PROD_W-4){1'b0}}, item.ch[3:0]};
    case (phase)
      ipv4atp_pkg::PH_OCT0: begin oct_idx = 2'd0; phase_adv = ipv4atp_pkg::PH_OCT1; end
      ipv4atp_pkg::PH_OCT1: begin oct_idx = 2'd1; phase_adv = ipv4atp_pkg::PH_OCT2; end
      ipv4atp_pkg::PH_OCT2: begin oct_idx = 2'd2; phase_adv = ipv4atp_pkg::PH_OCT3; end
      ipv4atp_pkg::PH_OCT3: begin oct_idx = 2'd3; phase_adv = ipv4atp_pkg::PH_PORT; end
      default:              begin oct_idx = 2'd3; phase_adv = ipv4atp_pkg::PH_PORT; end
    endcase
    sep_ok = ((item.ch == ipv4atp_pkg::CH_DOT) && (phase != ipv4atp_pkg::PH_OCT3))
          || ((item.ch == ipv4atp_pkg::CH_COLON) && (phase == ipv4atp_pkg::PH_OCT3));
  end

  always_comb begin
    phase_next      = phase;
    acc_next        = acc;
    digit_seen_next = digit_seen;
    octets_next     = octets;
    match_pos_next  = match_pos;
    err_next        = err;
    ended_next      = ended;
    result          = '0;

    if (!ended) begin
      if (item.ch == ipv4atp_pkg::CH_NUL) begin
        ended_next = 1'b1;
      end else begin
        if ((match_pos < ipv4atp_pkg::WORD_LEN)
            && (item.ch == ipv4atp_pkg::loop_char(match_pos))) begin
          match_pos_next = match_pos + 3'd1;
        end else begin
          match_pos_next = ipv4atp_pkg::WORD_FAIL;
        end

        if (err == ipv4atp_pkg::ERR_NONE) begin
          if (phase != ipv4atp_pkg::PH_PORT) begin
            if (is_digit) begin
              acc_next        = acc_sum[ipv4atp_pkg::ACC_W-1:0];
              digit_seen_next = 1'b1;
              if (acc_sum > ipv4atp_pkg::ACC_PROD_W'(ipv4atp_pkg::OCTET_MAX)) begin
                err_next = ipv4atp_pkg::ERR_NOT_NUMERIC;
              end
            end else if (sep_ok) begin
              if (!digit_seen) begin
                err_next = ipv4atp_pkg::ERR_NOT_NUMERIC;
              end else begin
                octets_next[oct_idx] = acc[7:0];
                phase_next           = phase_adv;
                acc_next             = '0;
                digit_seen_next      = 1'b0;
              end
            end else begin
              err_next = ipv4atp_pkg::ERR_NOT_NUMERIC;
            end
          end else begin
            if (is_digit) begin
              acc_next        = acc_sum[ipv4atp_pkg::ACC_W-1:0];
              digit_seen_next = 1'b1;
              if (acc_sum > ipv4atp_pkg::ACC_PROD_W'(ipv4atp_pkg::PORT_MAX)) begin
                err_next = ipv4atp_pkg::ERR_REJECTED;
              end
            end else begin
              err_next = ipv4atp_pkg::ERR_REJECTED;
            end
          end
        end
      end
    end

    // Verdict from the state after this character
    if (match_pos_next == ipv4atp_pkg::WORD_LEN) begin
      result.status = ipv4atp_pkg::ST_LOOPBACK;
    end else if (err_next != ipv4atp_pkg::ERR_NONE) begin
      case (err_next)
        ipv4atp_pkg::ERR_REJECTED: result.status = ipv4atp_pkg::ST_REJECTED;
        default:                   result.status = ipv4atp_pkg::ST_NOT_NUMERIC;
      endcase
    end else if (phase_next == ipv4atp_pkg::PH_PORT) begin
      if (!digit_seen_next) begin
        result.status = ipv4atp_pkg::ST_REJECTED;
      end else begin
        result.status      = ipv4atp_pkg::ST_IPV4;
        result.octet_a     = octets_next[0];
        result.octet_b     = octets_next[1];
        result.octet_c     = octets_next[2];
        result.octet_d     = octets_next[3];
        result.port_number = acc_next[15:0];
      end
    end else if (phase_next == ipv4atp_pkg::PH_OCT3) begin
      if (!digit_seen_next) begin
        result.status = ipv4atp_pkg::ST_NOT_NUMERIC;
      end else begin
        result.status      = ipv4atp_pkg::ST_IPV4;
        result.octet_a     = octets_next[0];
        result.octet_b     = octets_next[1];
        result.octet_c     = octets_next[2];
        result.octet_d     = acc_next[7:0];
        result.port_number = default_port;
      end
    end else begin
      result.status = ipv4atp_pkg::ST_NOT_NUMERIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last)) begin
      phase      <= ipv4atp_pkg::PH_OCT0;
      acc        <= '0;
      digit_seen <= 1'b0;
      octets     <= '{default: 8'h00};
      match_pos  <= 3'd0;
      err        <= ipv4atp_pkg::ERR_NONE;
      ended      <= 1'b0;
    end else if (step) begin
      phase      <= phase_next;
      acc        <= acc_next;
      digit_seen <= digit_seen_next;
      octets     <= octets_next;
      match_pos  <= match_pos_next;
      err        <= err_next;
      ended      <= ended_next;
    end
  end

endmodule

@@ rtl/ipv4_address_text_parser_core.sv @@
// Top level of the IPv4 dotted-quad address text parser.
// Streams an address string in, one character per item, and delivers one
// result item on the item marked last: status (0 IPv4, 1 loopback word
// "local", 2 not numeric, 3 bad port or text after the port), four octets
// and the port. Leading zeros are allowed, octets above 255 and ports above
// 65535 are refused, and a zero byte ends the string early. Without a
// ":port" part the default_port register (reset 27500) is reported.
// Throughput is one item per clock; the only back-pressure comes from a
// stalled result register, which holds back a last item, while non-last
// items keep flowing. Each item is held in the input register, and the
// parser step runs between that register and the result register, which
// loads as the last item leaves the input register. Write cfg_wr_en only
// while no string is in flight.
`include "ipv4_address_text_parser_core_macros.svh"
module ipv4_address_text_parser_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [15:0]            cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ipv4atp_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ipv4atp_pkg::out_item_t out_item
);

  // Default port register
  logic [15:0] default_port;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_port <= ipv4atp_pkg::DEFAULT_PORT_RESET;
    end else if (cfg_wr_en) begin
      default_port <= cfg_wr_data;
    end
  end

  // Input register: hold one character until the parser step takes it
  logic                  in_q_valid;
  ipv4atp_pkg::in_item_t in_q;
  logic                  out_free;
  logic                  advance;
  logic                  accept;

  // A last item needs a free result slot; other items advance at once
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_q_valid && (!in_q.last || out_free);
  assign in_stall = in_q_valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= in_item;
    end
  end

  // Parser step: state update and verdict for the held character
  ipv4atp_pkg::out_item_t result;

  ipv4atp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (in_q),
    .default_port (default_port),
    .result       (result)
  );

  // Result register: load on a last item, drop once taken downstream
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_q.last) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_q.last) begin
      out_item <= result;
    end
  end

  // Checks
  `IPV4ATP_ASSERT(a_result_from_last, $rose(out_valid) |-> $past(advance && in_q.last), "result without a last item")
  `IPV4ATP_ASSERT(a_no_overwrite, (out_valid && out_stall) |-> !(advance && in_q.last), "held result overwritten")
  `IPV4ATP_ASSERT(a_zero_fields, (out_valid && (out_item.status != ipv4atp_pkg::ST_IPV4)) |-> ((out_item.port_number == 16'd0) && (out_item.octet_a == 8'd0) && (out_item.octet_d == 8'd0)), "fields not cleared for a failed parse")
  `IPV4ATP_ASSERT_RST(a_reset_idle, rst |=> (!out_valid && !in_stall), "not idle after reset")

endmodule

@@ verif/ipv4_address_text_parser_core_test.sv @@
// Self-checking testbench for the IPv4 address text parser core.
`timescale 1ns / 1ps

module ipv4_address_text_parser_core_test;

  // Parser phases as the checker counts them: octets 0..3, then the port.
  localparam int unsigned LAST_OCTET = 3;
  localparam int unsigned PHASE_PORT = 4;
  localparam string       LOOP_WORD  = "local";

  localparam ipv4atp_pkg::out_item_t UNTYPED         = '0;
  localparam ipv4atp_pkg::out_item_t LOOPBACK_RES    =
    '{ipv4atp_pkg::ST_LOOPBACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};
  localparam ipv4atp_pkg::out_item_t NOT_NUMERIC_RES =
    '{ipv4atp_pkg::ST_NOT_NUMERIC, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};
  localparam ipv4atp_pkg::out_item_t REJECTED_RES    =
    '{ipv4atp_pkg::ST_REJECTED, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0};

  // Ways of damaging an otherwise well-formed address string.
  typedef enum int unsigned {
    SPOIL_NONE, SPOIL_BIG_OCTET, SPOIL_BIG_PORT, SPOIL_SWAP_CHAR,
    SPOIL_DROP_CHAR, SPOIL_TRAILER, SPOIL_SHORT, SPOIL_EMPTY_PORT
  } spoil_t;

  typedef logic [7:0] char_q_t [$];

  // One directed string: text, an optional zero byte and tail after it, and
  // the result where it can be written down directly.
  typedef struct {
    string                  text;
    bit                     nul;
    string                  tail;
    bit                     typed;
    ipv4atp_pkg::out_item_t res;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [15:0]            cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  ipv4atp_pkg::in_item_t  in_item;
  logic                   out_valid;
  logic                   out_stall;
  ipv4atp_pkg::out_item_t out_item;

  ipv4_address_text_parser_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

  // Checker copy of the parser state and of the default port register.
  int unsigned        pr_phase;
  logic [19:0]        pr_acc;
  bit                 pr_digit;
  logic [7:0]         pr_oct [4];
  logic [2:0]         pr_word;
  ipv4atp_pkg::err_t  pr_err;
  bit                 pr_ended;
  logic [15:0]        dflt_port;

  ipv4atp_pkg::out_item_t parsed_addr_q [$];
  bit                     typed_pend;
  ipv4atp_pkg::out_item_t typed_res;
  int unsigned            mismatches;
  int unsigned            items_sent;
  bit                     quiet;
  int unsigned            stall_left;

  row_t dir_rows [$] = '{
    '{"0.0.0.0", 0, "", 1,
      '{ipv4atp_pkg::ST_IPV4, 8'd0, 8'd0, 8'd0, 8'd0, ipv4atp_pkg::DEFAULT_PORT_RESET}},
    '{"255.255.255.255:65535", 0, "", 1,
      '{ipv4atp_pkg::ST_IPV4, 8'd255, 8'd255, 8'd255, 8'd255, 16'd65535}},
    '{"9.8.7.6:0", 0, "", 1,
      '{ipv4atp_pkg::ST_IPV4, 8'd9, 8'd8, 8'd7, 8'd6, 16'd0}},
    '{"192.168.1.20:8080", 0, "", 0, UNTYPED},
    '{"001.002.003.004:00080", 0, "", 0, UNTYPED},
    '{"local", 0, "", 1, LOOPBACK_RES},
    '{"local", 1, "zz", 1, LOOPBACK_RES},
    '{"loca", 0, "", 1, NOT_NUMERIC_RES},
    '{"localhost", 0, "", 1, NOT_NUMERIC_RES},
    '{"", 1, "", 1, NOT_NUMERIC_RES},
    '{"\377", 0, "", 1, NOT_NUMERIC_RES},
    '{"256.1.1.1", 0, "", 1, NOT_NUMERIC_RES},
    '{"1.2.3", 0, "", 1, NOT_NUMERIC_RES},
    '{"1..2.3.4", 0, "", 1, NOT_NUMERIC_RES},
    '{".1.2.3", 0, "", 1, NOT_NUMERIC_RES},
    '{"1:2.3.4", 0, "", 1, NOT_NUMERIC_RES},
    '{"1.2.3.4.5", 0, "", 1, NOT_NUMERIC_RES},
    '{"1.2.3.4x", 0, "", 1, NOT_NUMERIC_RES},
    '{"1.2.3.4:", 0, "", 1, REJECTED_RES},
    '{"1.2.3.4:65536", 0, "", 1, REJECTED_RES},
    '{"1.2.3.4:80x", 0, "", 1, REJECTED_RES},
    '{"1.2.3.4::", 0, "", 1, REJECTED_RES},
    '{"10.0.0.1", 1, "9.9", 0, UNTYPED},
    '{"10.0.0.1", 1, "", 0, UNTYPED}
  };

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic void clear_parse_state();
    pr_phase = 0;
    pr_acc   = '0;
    pr_digit = 1'b0;
    foreach (pr_oct[k]) pr_oct[k] = '0;
    pr_word  = '0;
    pr_err   = ipv4atp_pkg::ERR_NONE;
    pr_ended = 1'b0;
  endfunction

  // Advance the parser by one character; on the last item fill in the
  // result the block must deliver, clear the parse and return 1.
  function automatic bit parse_char(input ipv4atp_pkg::in_item_t it,
                                    output ipv4atp_pkg::out_item_t res);
    logic [7:0]           c;
    bit                   is_digit;
    ipv4atp_pkg::status_t st;
    logic [15:0]          port;
    c   = it.ch;
    res = '0;
    if (!pr_ended) begin
      if (c == ipv4atp_pkg::CH_NUL) begin
        // The string ends here; drop everything up to the last item.
        pr_ended = 1'b1;
      end else begin
        is_digit = (c >= ipv4atp_pkg::CH_DIG0) && (c <= ipv4atp_pkg::CH_DIG9);
        if (pr_word < ipv4atp_pkg::WORD_LEN && c == LOOP_WORD[pr_word]) pr_word++;
        else pr_word = ipv4atp_pkg::WORD_FAIL;
        // Keep only the first error found.
        if (pr_err == ipv4atp_pkg::ERR_NONE) begin
          if (pr_phase < PHASE_PORT) begin
            if (is_digit) begin
              pr_acc   = pr_acc * 20'd10 + 20'(c - ipv4atp_pkg::CH_DIG0);
              pr_digit = 1'b1;
              if (pr_acc > ipv4atp_pkg::OCTET_MAX) pr_err = ipv4atp_pkg::ERR_NOT_NUMERIC;
            end else if ((c == ipv4atp_pkg::CH_DOT && pr_phase < LAST_OCTET) ||
                         (c == ipv4atp_pkg::CH_COLON && pr_phase == LAST_OCTET)) begin
              if (!pr_digit) begin
                pr_err = ipv4atp_pkg::ERR_NOT_NUMERIC;
              end else begin
                pr_oct[pr_phase] = pr_acc[7:0];
                pr_phase++;
                pr_acc   = '0;
                pr_digit = 1'b0;
              end
            end else begin
              pr_err = ipv4atp_pkg::ERR_NOT_NUMERIC;
            end
          end else if (is_digit) begin
            pr_acc   = pr_acc * 20'd10 + 20'(c - ipv4atp_pkg::CH_DIG0);
            pr_digit = 1'b1;
            if (pr_acc > ipv4atp_pkg::PORT_MAX) pr_err = ipv4atp_pkg::ERR_REJECTED;
          end else begin
            pr_err = ipv4atp_pkg::ERR_REJECTED;
          end
        end
      end
    end
    if (!it.last) return 1'b0;

    port = '0;
    if (pr_word == ipv4atp_pkg::WORD_LEN) begin
      st = ipv4atp_pkg::ST_LOOPBACK;
    end else if (pr_err != ipv4atp_pkg::ERR_NONE) begin
      st = ipv4atp_pkg::status_t'(pr_err);
    end else if (pr_phase < LAST_OCTET) begin
      st = ipv4atp_pkg::ST_NOT_NUMERIC;
    end else if (!pr_digit) begin
      st = (pr_phase == LAST_OCTET) ? ipv4atp_pkg::ST_NOT_NUMERIC
                                    : ipv4atp_pkg::ST_REJECTED;
    end else begin
      st = ipv4atp_pkg::ST_IPV4;
      if (pr_phase == LAST_OCTET) begin
        pr_oct[3] = pr_acc[7:0];
        port      = dflt_port;
      end else begin
        port = pr_acc[15:0];
      end
    end
    res.status = st;
    if (st == ipv4atp_pkg::ST_IPV4) begin
      res.octet_a     = pr_oct[0];
      res.octet_b     = pr_oct[1];
      res.octet_c     = pr_oct[2];
      res.octet_d     = pr_oct[3];
      res.port_number = port;
    end
    clear_parse_state();
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Sample both channels at the rising edge: check a delivered result
  // against the oldest expectation first, then predict from a taken item.
  always @(posedge clk) begin : monitor
    ipv4atp_pkg::out_item_t want;
    ipv4atp_pkg::out_item_t got;
    if (rst) begin
      clear_parse_state();
      dflt_port = ipv4atp_pkg::DEFAULT_PORT_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_item;
        if (parsed_addr_q.size() == 0) begin
          $error("result item with no expectation waiting: status %0d", got.status);
          mismatches++;
        end else begin
          want = parsed_addr_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("octet_a", want.octet_a, got.octet_a);
          check_field("octet_b", want.octet_b, got.octet_b);
          check_field("octet_c", want.octet_c, got.octet_c);
          check_field("octet_d", want.octet_d, got.octet_d);
          check_field("port_number", want.port_number, got.port_number);
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_char(in_item, want))
          parsed_addr_q.push_back(typed_pend ? typed_res : want);
      end
      if (cfg_wr_en) dflt_port = cfg_wr_data;
    end
  end

  // Hold the result channel off in short random bursts, starting no new
  // burst once the run has gone quiet.
  always @(negedge clk) begin
    if (stall_left != 0) stall_left--;
    else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_stall <= (stall_left != 0);
  end

  function automatic void add_text(ref char_q_t s, input string t);
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
  endfunction

  // Decimal text, now and then with leading zeros.
  function automatic string dec_text(int unsigned v);
    string z;
    z = "";
    if ($urandom_range(0, 5) == 0) z = ($urandom_range(0, 1) == 0) ? "0" : "00";
    return {z, $sformatf("%0d", v)};
  endfunction

  function automatic int unsigned pick_octet();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return ipv4atp_pkg::OCTET_MAX;
      default: return $urandom_range(0, ipv4atp_pkg::OCTET_MAX);
    endcase
  endfunction

  function automatic int unsigned pick_port();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return ipv4atp_pkg::PORT_MAX;
      2:       return $urandom_range(0, 999);
      default: return $urandom_range(0, ipv4atp_pkg::PORT_MAX);
    endcase
  endfunction

  // Build a dotted quad with an optional port, then damage it as asked.
  function automatic void build_address(ref char_q_t s, input spoil_t spoil);
    int unsigned n_oct;
    int unsigned bad_pos;
    bit          with_port;
    n_oct   = (spoil == SPOIL_SHORT) ? $urandom_range(1, 3) : 4;
    bad_pos = $urandom_range(0, n_oct - 1);
    for (int i = 0; i < n_oct; i++) begin
      if (i != 0) s.push_back(ipv4atp_pkg::CH_DOT);
      if (spoil == SPOIL_BIG_OCTET && i == bad_pos) add_text(s, dec_text($urandom_range(256, 999)));
      else add_text(s, dec_text(pick_octet()));
    end
    with_port = ($urandom_range(0, 1) == 1) || spoil == SPOIL_BIG_PORT ||
                spoil == SPOIL_EMPTY_PORT;
    if (with_port) begin
      s.push_back(ipv4atp_pkg::CH_COLON);
      if (spoil == SPOIL_BIG_PORT) add_text(s, dec_text($urandom_range(65536, 99999)));
      else if (spoil != SPOIL_EMPTY_PORT) add_text(s, dec_text(pick_port()));
    end
    case (spoil)
      SPOIL_SWAP_CHAR: s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
      SPOIL_DROP_CHAR: s.delete($urandom_range(0, s.size() - 1));
      SPOIL_TRAILER:   repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endfunction

  // Drive one string, one item per character, last on the final one.
  task automatic send_string(input char_q_t s, input bit typed,
                             input ipv4atp_pkg::out_item_t res);
    bit gappy;
    gappy = ($urandom_range(0, 9) < 7);
    foreach (s[i]) begin
      if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      @(negedge clk);
      in_valid <= 1'b1;
      in_item  <= ipv4atp_pkg::in_item_t'{s[i], i == s.size() - 1};
      if (i == s.size() - 1) begin
        typed_pend = typed;
        typed_res  = res;
      end
      do @(posedge clk); while (in_stall);
      items_sent++;
    end
  endtask

  task automatic send_random_string();
    char_q_t     s;
    int unsigned pick;
    string       noise_set;
    noise_set = "0123456789.:";
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      build_address(s, SPOIL_NONE);
    end else if (pick < 72) begin
      build_address(s, spoil_t'($urandom_range(SPOIL_BIG_OCTET, SPOIL_EMPTY_PORT)));
    end else if (pick < 80) begin
      case ($urandom_range(0, 7))
        0:       add_text(s, "loca");
        1:       add_text(s, "locale");
        2:       add_text(s, "lOcal");
        3:       add_text(s, "local:80");
        4:       add_text(s, "llocal");
        default: add_text(s, LOOP_WORD);
      endcase
    end else if (pick < 88) begin
      // Good address cut short by a zero byte, with zero to four junk bytes after it.
      build_address(s, SPOIL_NONE);
      s.push_back(ipv4atp_pkg::CH_NUL);
      repeat ($urandom_range(0, 4)) s.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 1) == 0) s.push_back(noise_set[$urandom_range(0, 11)]);
        else s.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      s.push_back(ipv4atp_pkg::CH_NUL);
    end
    send_string(s, 1'b0, UNTYPED);
  endtask

  // Let every pending result drain and the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (parsed_addr_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_default_port(input logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    char_q_t     s;
    logic [15:0] port_set [4];
    int unsigned phase_start;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_item     = '0;
    out_stall   = 1'b0;
    typed_pend  = 1'b0;
    typed_res   = '0;
    mismatches  = 0;
    items_sent  = 0;
    quiet       = 1'b0;
    stall_left  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed strings run with the default port straight out of reset.
    foreach (dir_rows[r]) begin
      s = {};
      add_text(s, dir_rows[r].text);
      if (dir_rows[r].nul) begin
        s.push_back(ipv4atp_pkg::CH_NUL);
        add_text(s, dir_rows[r].tail);
      end
      send_string(s, dir_rows[r].typed, dir_rows[r].res);
    end

    // Random strings under several default ports, extremes first.
    port_set = '{16'd0, 16'hffff, 16'($urandom_range(1, 65534)), 16'($urandom_range(1, 65534))};
    foreach (port_set[p]) begin
      set_default_port(port_set[p]);
      phase_start = items_sent;
      while (items_sent - phase_start < 100) begin
        // Run the tail of the final phase with no idling at all.
        if (p == 3 && items_sent - phase_start >= 65) quiet = 1'b1;
        send_random_string();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ ipv4_address_text_parser_core.f @@
+incdir+rtl
rtl/ipv4atp_pkg.sv
rtl/ipv4atp_parser.sv
rtl/ipv4_address_text_parser_core.sv
verif/ipv4_address_text_parser_core_test.sv
